// ===== rtl/core/rolling_hash_substring_matcher_defines.svh =====
// Assertion macros used by the matcher top module.
`ifndef ROLLING_HASH_SUBSTRING_MATCHER_DEFINES_SVH
`define ROLLING_HASH_SUBSTRING_MATCHER_DEFINES_SVH

// Condition holds in the same cycle.
`define RHSM_ASSERT_SAME(lbl, clk_i, rst_i, cond, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (rst_i) (cond) |-> (prop)) \
    else $error(msg);

// Condition holds in the following cycle.
`define RHSM_ASSERT_NEXT(lbl, clk_i, rst_i, cond, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (rst_i) (cond) |=> (prop)) \
    else $error(msg);

`endif

// ===== rtl/core/rhsm_pkg.sv =====
`timescale 1ns / 1ps

package rhsm_pkg;

  localparam int HASH_BITS        = 30;
  localparam int BYTE_BITS        = 8;
  localparam int ACTION_BITS      = 2;
  localparam int RING_DEPTH       = 128;
  localparam int RING_BITS        = 7;
  localparam int FOLD_ENTRIES     = 256;
  localparam int MATCH_START_BITS = 24;
  localparam int RESULT_DEPTH     = 8;
  localparam int RESULT_PTR_BITS  = 3;
  localparam int RESULT_CNT_BITS  = 4;
  localparam int PROD_BITS        = 2 * HASH_BITS;
  localparam int NARROW_BITS      = HASH_BITS + BYTE_BITS;
  localparam int QUOT_BITS        = HASH_BITS + 1;

  localparam logic [HASH_BITS-1:0] HASH_MOD    = 30'd1000000007;
  localparam logic [HASH_BITS:0]   HASH_MOD_X2 = {HASH_MOD, 1'b0};
  localparam logic [BYTE_BITS-1:0] HASH_BASE   = 8'd131;
  localparam logic [63:0]          BARRETT_WIDE = (64'd1 << PROD_BITS) / 64'(HASH_MOD);
  localparam logic [QUOT_BITS-1:0] BARRETT_MU  = BARRETT_WIDE[QUOT_BITS-1:0];

  typedef enum logic [ACTION_BITS-1:0] {
    ACT_NEW_LINE = 2'd0,
    ACT_PATTERN  = 2'd1,
    ACT_TEXT     = 2'd2
  } action_t;

  typedef enum logic [1:0] {
    OP_NONE,
    OP_CLEAR,
    OP_PATTERN,
    OP_TEXT
  } op_t;

  typedef struct packed {
    logic tok;
    logic chk;
  } match_req_t;

  typedef struct packed {
    logic done;
    logic hit;
  } match_rsp_t;

  // (a + b) mod M for a below M and b below 2^30
  function automatic logic [HASH_BITS-1:0] fold_sum(input logic [HASH_BITS-1:0] a,
                                                    input logic [HASH_BITS-1:0] b);
    logic [HASH_BITS:0] sum;
    logic [HASH_BITS:0] res;
    sum = {1'b0, a} + {1'b0, b};
    if (sum >= HASH_MOD_X2) begin
      res = sum - HASH_MOD_X2;
    end else if (sum >= {1'b0, HASH_MOD}) begin
      res = sum - {1'b0, HASH_MOD};
    end else begin
      res = sum;
    end
    return res[HASH_BITS-1:0];
  endfunction

endpackage

// ===== rtl/core/rhsm_ring.sv =====
`timescale 1ns / 1ps

module rhsm_ring (
  input  logic                           clk,
  input  logic                           power_we,
  input  logic [rhsm_pkg::RING_BITS-1:0] power_waddr,
  input  logic [rhsm_pkg::HASH_BITS-1:0] power_wdata,
  input  logic [rhsm_pkg::RING_BITS-1:0] power_raddr,
  output logic [rhsm_pkg::HASH_BITS-1:0] power_rdata,
  input  logic                           prefix_we,
  input  logic [rhsm_pkg::RING_BITS-1:0] prefix_waddr,
  input  logic [rhsm_pkg::HASH_BITS-1:0] prefix_wdata,
  input  logic [rhsm_pkg::RING_BITS-1:0] prefix_raddr,
  output logic [rhsm_pkg::HASH_BITS-1:0] prefix_rdata
);
  import rhsm_pkg::*;

  logic [HASH_BITS-1:0] power_mem  [RING_DEPTH];
  logic [HASH_BITS-1:0] prefix_mem [RING_DEPTH];

  always_ff @(posedge clk) begin
    if (power_we) begin
      power_mem[power_waddr] <= power_wdata;
    end
    power_rdata <= power_mem[power_raddr];
  end

  always_ff @(posedge clk) begin
    if (prefix_we) begin
      prefix_mem[prefix_waddr] <= prefix_wdata;
    end
    prefix_rdata <= prefix_mem[prefix_raddr];
  end

endmodule

// ===== rtl/core/rhsm_match.sv =====
`timescale 1ns / 1ps

module rhsm_match (
  input  logic                                  clk,
  input  logic                                  rst,
  input  rhsm_pkg::match_req_t                  req,
  input  logic [rhsm_pkg::HASH_BITS-1:0]        window_hash,
  input  logic [rhsm_pkg::HASH_BITS-1:0]        prior_hash,
  input  logic [rhsm_pkg::HASH_BITS-1:0]        start_power,
  input  logic [rhsm_pkg::HASH_BITS-1:0]        pat_hash,
  input  logic [rhsm_pkg::MATCH_START_BITS-1:0] req_start,
  output rhsm_pkg::match_rsp_t                  rsp,
  output logic [rhsm_pkg::MATCH_START_BITS-1:0] rsp_start
);
  import rhsm_pkg::*;

  localparam int RES_BITS  = HASH_BITS + 2;
  localparam int WIDE_BITS = 2 * QUOT_BITS;
  localparam int PM_BITS   = QUOT_BITS + HASH_BITS;

  logic                        tok4, chk4;
  logic [HASH_BITS-1:0]        win4, prior4;
  logic [PROD_BITS-1:0]        prod4;
  logic [MATCH_START_BITS-1:0] start4;
  logic [HASH_BITS:0]          diff_wide;
  logic [WIDE_BITS-1:0]        quot_wide;

  logic                        tok5, chk5;
  logic [HASH_BITS-1:0]        diff5;
  logic [QUOT_BITS-1:0]        quot5;
  logic [RES_BITS-1:0]         low5;
  logic [MATCH_START_BITS-1:0] start5;
  logic [PM_BITS-1:0]          quot_mod;

  logic                        tok6, chk6;
  logic [HASH_BITS-1:0]        diff6;
  logic [RES_BITS-1:0]         rem6;
  logic [MATCH_START_BITS-1:0] start6;
  logic [RES_BITS-1:0]         rhs_wide;

  always_ff @(posedge clk) begin
    if (rst) begin
      tok4 <= 1'b0;
      tok5 <= 1'b0;
      tok6 <= 1'b0;
    end else begin
      tok4 <= req.tok;
      tok5 <= tok4;
      tok6 <= tok5;
    end
  end

  always_ff @(posedge clk) begin
    chk4   <= req.chk;
    win4   <= window_hash;
    prior4 <= prior_hash;
    prod4  <= PROD_BITS'(pat_hash) * PROD_BITS'(start_power);
    start4 <= req_start;
  end

  assign diff_wide = (win4 >= prior4) ? ({1'b0, win4} - {1'b0, prior4})
                                      : ({1'b0, win4} + {1'b0, HASH_MOD} - {1'b0, prior4});
  assign quot_wide = WIDE_BITS'(prod4[PROD_BITS-1:HASH_BITS-1]) * WIDE_BITS'(BARRETT_MU);

  always_ff @(posedge clk) begin
    chk5   <= chk4;
    diff5  <= diff_wide[HASH_BITS-1:0];
    quot5  <= quot_wide[WIDE_BITS-1:QUOT_BITS];
    low5   <= prod4[RES_BITS-1:0];
    start5 <= start4;
  end

  assign quot_mod = PM_BITS'(quot5) * PM_BITS'(HASH_MOD);

  always_ff @(posedge clk) begin
    chk6   <= chk5;
    diff6  <= diff5;
    rem6   <= low5 - quot_mod[RES_BITS-1:0];
    start6 <= start5;
  end

  always_comb begin
    if (rem6 >= RES_BITS'(HASH_MOD_X2)) begin
      rhs_wide = rem6 - RES_BITS'(HASH_MOD_X2);
    end else if (rem6 >= RES_BITS'(HASH_MOD)) begin
      rhs_wide = rem6 - RES_BITS'(HASH_MOD);
    end else begin
      rhs_wide = rem6;
    end
  end

  assign rsp.done  = tok6;
  assign rsp.hit   = tok6 && chk6 && (rhs_wide[HASH_BITS-1:0] == diff6);
  assign rsp_start = start6;

endmodule

// ===== rtl/core/rhsm_result_fifo.sv =====
`timescale 1ns / 1ps

module rhsm_result_fifo (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  push,
  input  logic [rhsm_pkg::MATCH_START_BITS-1:0] push_data,
  output logic                                  head_valid,
  input  logic                                  head_ready,
  output logic [rhsm_pkg::MATCH_START_BITS-1:0] head_data,
  output logic [rhsm_pkg::RESULT_CNT_BITS-1:0]  count
);
  import rhsm_pkg::*;

  logic [MATCH_START_BITS-1:0] slots [RESULT_DEPTH];
  logic [RESULT_PTR_BITS-1:0]  wr_ptr, rd_ptr;
  logic                        pop;

  assign head_valid = (count != '0);
  assign head_data  = slots[rd_ptr];
  assign pop        = head_valid && head_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      count <= count + RESULT_CNT_BITS'(push) - RESULT_CNT_BITS'(pop);
    end
  end

endmodule

// ===== rtl/core/rolling_hash_substring_matcher.sv =====
// Rabin-Karp byte-stream matcher, base 131, modulus 1000000007.
// The intake register holds one item at a time; the shared power multiply and fold
//   close their loop on the power registers through the s2 register.
// A match result passes the s2, s3 and match-stage registers into the result queue.
// Up to 8 results queue at the output; intake pauses once all are reserved.
// Reset (rst, synchronous) clears hashes, counters and queue; rings keep no reset.
`timescale 1ns / 1ps
`include "rolling_hash_substring_matcher_defines.svh"

module rolling_hash_substring_matcher #(
  parameter int MAX_PATTERN   = 64,
  parameter int POSITION_BITS = 24
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  item_valid,
  output logic                                  item_ready,
  input  logic [rhsm_pkg::ACTION_BITS-1:0]      action,
  input  logic [rhsm_pkg::BYTE_BITS-1:0]        char_code,
  output logic                                  match_valid,
  input  logic                                  match_ready,
  output logic [rhsm_pkg::MATCH_START_BITS-1:0] match_start
);
  import rhsm_pkg::*;

  localparam int PATTERN_LIMIT = (MAX_PATTERN < RING_DEPTH - 1) ? MAX_PATTERN : RING_DEPTH - 1;
  localparam logic [RING_BITS-1:0] PATTERN_LIMIT_CODE = RING_BITS'(PATTERN_LIMIT);

  logic [HASH_BITS-1:0] fold_tbl [FOLD_ENTRIES];

  for (genvar g = 0; g < FOLD_ENTRIES; g++) begin : g_fold
    localparam logic [63:0] FOLD_VALUE = (64'(g) << HASH_BITS) % 64'(HASH_MOD);
    assign fold_tbl[g] = FOLD_VALUE[HASH_BITS-1:0];
  end

  logic                       item_accept;
  logic [RING_BITS-1:0]       pattern_len;
  logic [HASH_BITS-1:0]       pattern_hash, pattern_power, text_power, prefix_hash;
  logic [POSITION_BITS:0]     text_count;
  logic                       text_started;

  logic                       s1_valid;
  logic [ACTION_BITS-1:0]     s1_action;
  logic [BYTE_BITS-1:0]       s1_byte;
  op_t                        s1_op;
  logic                       s1_tok, s1_chk;
  logic [HASH_BITS-1:0]       mul_power;
  logic [NARROW_BITS-1:0]     s1_prod_byte, s1_prod_base;
  logic [POSITION_BITS:0]     count_inc, start_full, prior_full;

  op_t                        s2_op;
  logic                       s2_tok, s2_chk, s2_first;
  logic [NARROW_BITS-1:0]     s2_prod_byte, s2_prod_base;
  logic [RING_BITS-1:0]       s2_slot, s2_start_slot, s2_prior_slot;
  logic [MATCH_START_BITS-1:0] s2_start;
  logic [HASH_BITS-1:0]       byte_term, power_next;

  op_t                        s3_op;
  logic                       s3_tok, s3_chk, s3_first;
  logic [HASH_BITS-1:0]       s3_term;
  logic [RING_BITS-1:0]       s3_slot;
  logic [MATCH_START_BITS-1:0] s3_start;
  logic [HASH_BITS-1:0]       acc_base, acc_sum, prior_hash;

  logic [HASH_BITS-1:0]       power_rdata, prefix_rdata;
  match_req_t                 req;
  match_rsp_t                 rsp;
  logic [MATCH_START_BITS-1:0] rsp_start;
  logic [RESULT_CNT_BITS-1:0] fifo_count, inflight, reserved;
  logic                       fifo_push;

  assign reserved    = inflight + fifo_count;
  assign item_ready  = !s1_valid && (reserved < RESULT_CNT_BITS'(RESULT_DEPTH));
  assign item_accept = item_valid && item_ready;

  // intake register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= item_accept;
    end
  end

  always_ff @(posedge clk) begin
    if (item_accept) begin
      s1_action <= action;
      s1_byte   <= char_code;
    end
  end

  assign count_inc  = text_count + 1'b1;
  assign start_full = count_inc - (POSITION_BITS + 1)'(pattern_len);
  assign prior_full = text_count - (POSITION_BITS + 1)'(pattern_len);
  assign s1_tok     = s1_valid && (action_t'(s1_action) == ACT_TEXT);

  always_comb begin
    s1_op  = OP_NONE;
    s1_chk = 1'b0;
    if (s1_valid) begin
      unique case (action_t'(s1_action))
        ACT_NEW_LINE: begin
          s1_op = OP_CLEAR;
        end
        ACT_PATTERN: begin
          if (!text_started && (pattern_len < PATTERN_LIMIT_CODE)) begin
            s1_op = OP_PATTERN;
          end
        end
        ACT_TEXT: begin
          if (!text_count[POSITION_BITS]) begin
            s1_op  = OP_TEXT;
            s1_chk = (pattern_len != '0) &&
                     (count_inc >= (POSITION_BITS + 1)'(pattern_len));
          end
        end
        default: begin
          s1_op = OP_NONE;
        end
      endcase
    end
  end

  assign mul_power    = (s1_op == OP_TEXT) ? text_power : pattern_power;
  assign s1_prod_byte = NARROW_BITS'(s1_byte) * NARROW_BITS'(mul_power);
  assign s1_prod_base = NARROW_BITS'(mul_power) * NARROW_BITS'(HASH_BASE);

  // counters and flags advance at intake
  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_len  <= '0;
      text_count   <= '0;
      text_started <= 1'b0;
    end else begin
      unique case (s1_op)
        OP_CLEAR: begin
          pattern_len <= '0;
          text_count  <= '0;
        end
        OP_PATTERN: pattern_len <= pattern_len + 1'b1;
        OP_TEXT:    text_count  <= count_inc;
        default: begin
        end
      endcase
      if (s1_tok) begin
        text_started <= 1'b1;
      end else if (s1_op == OP_CLEAR) begin
        text_started <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_op  <= OP_NONE;
      s2_tok <= 1'b0;
      s3_op  <= OP_NONE;
      s3_tok <= 1'b0;
    end else begin
      s2_op  <= s1_op;
      s2_tok <= s1_tok;
      s3_op  <= s2_op;
      s3_tok <= s2_tok;
    end
  end

  always_ff @(posedge clk) begin
    s2_chk        <= s1_chk;
    s2_first      <= (start_full == '0);
    s2_prod_byte  <= s1_prod_byte;
    s2_prod_base  <= s1_prod_base;
    s2_slot       <= text_count[RING_BITS-1:0];
    s2_start_slot <= start_full[RING_BITS-1:0];
    s2_prior_slot <= prior_full[RING_BITS-1:0];
    s2_start      <= MATCH_START_BITS'(start_full[POSITION_BITS-1:0]);
  end

  // fold the upper byte of each product through the residue table
  assign byte_term  = fold_sum(fold_tbl[s2_prod_byte[NARROW_BITS-1:HASH_BITS]],
                               s2_prod_byte[HASH_BITS-1:0]);
  assign power_next = fold_sum(fold_tbl[s2_prod_base[NARROW_BITS-1:HASH_BITS]],
                               s2_prod_base[HASH_BITS-1:0]);

  always_ff @(posedge clk) begin
    if (rst) begin
      text_power    <= HASH_BITS'(1);
      pattern_power <= HASH_BITS'(1);
    end else begin
      unique case (s2_op)
        OP_CLEAR: begin
          text_power    <= HASH_BITS'(1);
          pattern_power <= HASH_BITS'(1);
        end
        OP_PATTERN: pattern_power <= power_next;
        OP_TEXT:    text_power    <= power_next;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    s3_chk   <= s2_chk;
    s3_first <= s2_first;
    s3_term  <= byte_term;
    s3_slot  <= s2_slot;
    s3_start <= s2_start;
  end

  assign acc_base   = (s3_op == OP_TEXT) ? prefix_hash : pattern_hash;
  assign acc_sum    = fold_sum(s3_term, acc_base);
  assign prior_hash = s3_first ? '0 : prefix_rdata;

  always_ff @(posedge clk) begin
    if (rst) begin
      prefix_hash  <= '0;
      pattern_hash <= '0;
    end else begin
      unique case (s3_op)
        OP_CLEAR: begin
          prefix_hash  <= '0;
          pattern_hash <= '0;
        end
        OP_PATTERN: pattern_hash <= acc_sum;
        OP_TEXT:    prefix_hash  <= acc_sum;
        default: begin
        end
      endcase
    end
  end

  rhsm_ring u_ring (
    .clk          (clk),
    .power_we     (s1_op == OP_TEXT),
    .power_waddr  (text_count[RING_BITS-1:0]),
    .power_wdata  (text_power),
    .power_raddr  (s2_start_slot),
    .power_rdata  (power_rdata),
    .prefix_we    (s3_op == OP_TEXT),
    .prefix_waddr (s3_slot),
    .prefix_wdata (acc_sum),
    .prefix_raddr (s2_prior_slot),
    .prefix_rdata (prefix_rdata)
  );

  assign req.tok = s3_tok;
  assign req.chk = s3_chk;

  rhsm_match u_match (
    .clk         (clk),
    .rst         (rst),
    .req         (req),
    .window_hash (acc_sum),
    .prior_hash  (prior_hash),
    .start_power (power_rdata),
    .pat_hash    (pattern_hash),
    .req_start   (s3_start),
    .rsp         (rsp),
    .rsp_start   (rsp_start)
  );

  // reserve a result slot for every text transaction until its check retires
  always_ff @(posedge clk) begin
    if (rst) begin
      inflight <= '0;
    end else begin
      inflight <= inflight
                + RESULT_CNT_BITS'(item_accept && (action_t'(action) == ACT_TEXT))
                - RESULT_CNT_BITS'(rsp.done);
    end
  end

  assign fifo_push = rsp.done && rsp.hit;

  rhsm_result_fifo u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push       (fifo_push),
    .push_data  (rsp_start),
    .head_valid (match_valid),
    .head_ready (match_ready),
    .head_data  (match_start),
    .count      (fifo_count)
  );

  `RHSM_ASSERT_NEXT(a_intake_spacing, clk, rst, item_accept, !item_ready,
                    "intake accepted transactions in adjacent cycles")
  `RHSM_ASSERT_SAME(a_push_has_room, clk, rst, fifo_push,
                    fifo_count < RESULT_CNT_BITS'(RESULT_DEPTH),
                    "result pushed into a full queue")
  `RHSM_ASSERT_SAME(a_reserve_bound, clk, rst, 1'b1,
                    reserved <= RESULT_CNT_BITS'(RESULT_DEPTH),
                    "result reservations exceed queue depth")
  `RHSM_ASSERT_SAME(a_retire_has_token, clk, rst, rsp.done, inflight != '0,
                    "check retired with no reservation outstanding")

endmodule

// ===== dv/rolling_hash_substring_matcher_tb.sv =====
`timescale 1ns / 1ps

module rolling_hash_substring_matcher_tb;
  import rhsm_pkg::*;

  localparam int MAX_PATTERN   = 64;
  localparam int POSITION_BITS = 24;
  localparam int PATTERN_CAP   = (MAX_PATTERN < RING_DEPTH - 1) ? MAX_PATTERN : RING_DEPTH - 1;
  localparam logic [ACTION_BITS-1:0] ACT_UNUSED = 2'd3;
  localparam int ITEM_TARGET   = 700;
  localparam int CYCLE_LIMIT   = 600000;
  localparam int DRAIN_LIMIT   = 20000;
  localparam int TAIL_CYCLES   = 40;

  class match_scoreboard;
    bit [6:0]                  pat_len;
    bit [HASH_BITS-1:0]        pat_hash, pat_pow, txt_pow, prefix;
    bit [POSITION_BITS:0]      txt_count;
    bit                        txt_started;
    bit [HASH_BITS-1:0]        prefix_ring[RING_DEPTH];
    bit [HASH_BITS-1:0]        power_ring[RING_DEPTH];
    logic [MATCH_START_BITS-1:0] start_q[$];
    int failures, matches_checked, expected_total;
    int clears, pattern_bytes, text_bytes, ignored;

    function new();
      clear_state();
    endfunction

    function void clear_state();
      pat_len     = '0;
      pat_hash    = '0;
      pat_pow     = HASH_BITS'(1);
      txt_pow     = HASH_BITS'(1);
      prefix      = '0;
      txt_count   = '0;
      txt_started = 1'b0;
    endfunction

    function bit [HASH_BITS-1:0] mul_mod(bit [HASH_BITS-1:0] a, bit [HASH_BITS-1:0] b);
      return HASH_BITS'((64'(a) * 64'(b)) % 64'(HASH_MOD));
    endfunction

    function bit [HASH_BITS-1:0] add_mod(bit [HASH_BITS-1:0] a, bit [HASH_BITS-1:0] b);
      return HASH_BITS'((64'(a) + 64'(b)) % 64'(HASH_MOD));
    endfunction

    function void flag(string msg);
      failures++;
      if (failures <= 10) $display("%s", msg);
    endfunction

    function int effective();
      return clears + pattern_bytes + text_bytes + ignored;
    endfunction

    function int pending();
      return start_q.size();
    endfunction

    function void note_item(logic [ACTION_BITS-1:0] act, logic [BYTE_BITS-1:0] code);
      bit [POSITION_BITS:0] win_start;
      bit [RING_BITS-1:0]   slot;
      bit [HASH_BITS-1:0]   lead, diff, scaled;
      case (act)
        ACT_NEW_LINE: begin
          clear_state();
          clears++;
        end
        ACT_PATTERN: begin
          if (!txt_started && pat_len < PATTERN_CAP) begin
            pat_hash = add_mod(pat_hash, mul_mod(HASH_BITS'(code), pat_pow));
            pat_pow  = mul_mod(pat_pow, HASH_BITS'(HASH_BASE));
            pat_len++;
            pattern_bytes++;
          end else begin
            ignored++;
          end
        end
        ACT_TEXT: begin
          txt_started = 1'b1;
          if (txt_count < (1 << POSITION_BITS)) begin
            text_bytes++;
            slot = txt_count[RING_BITS-1:0];
            prefix = add_mod(prefix, mul_mod(HASH_BITS'(code), txt_pow));
            prefix_ring[slot] = prefix;
            power_ring[slot]  = txt_pow;
            txt_pow = mul_mod(txt_pow, HASH_BITS'(HASH_BASE));
            txt_count++;
            if (pat_len != 0 && txt_count >= (POSITION_BITS+1)'(pat_len)) begin
              win_start = txt_count - (POSITION_BITS+1)'(pat_len);
              slot = win_start[RING_BITS-1:0] - 1'b1;
              lead = (win_start == 0) ? '0 : prefix_ring[slot];
              diff = HASH_BITS'((64'(prefix) + 64'(HASH_MOD) - 64'(lead)) % 64'(HASH_MOD));
              scaled = mul_mod(pat_hash, power_ring[win_start[RING_BITS-1:0]]);
              if (diff == scaled) begin
                start_q.push_back(win_start[MATCH_START_BITS-1:0]);
                expected_total++;
              end
            end
          end else begin
            ignored++;
          end
        end
        default: ignored++;
      endcase
    endfunction

    function void check_match(logic [MATCH_START_BITS-1:0] got);
      logic [MATCH_START_BITS-1:0] want;
      if (start_q.size() == 0) begin
        flag($sformatf("unexpected match_start %0d with nothing expected", got));
      end else begin
        want = start_q.pop_front();
        matches_checked++;
        if (got !== want)
          flag($sformatf("match_start mismatch: expected %0d, got %0d", want, got));
      end
    endfunction

    function void report_leftovers();
      while (start_q.size() != 0)
        flag($sformatf("match_start %0d expected but never seen", start_q.pop_front()));
    endfunction
  endclass

  logic                        clk = 1'b0;
  logic                        rst = 1'b1;
  logic                        item_valid = 1'b0;
  logic                        item_ready;
  logic [ACTION_BITS-1:0]      action = '0;
  logic [BYTE_BITS-1:0]        char_code = '0;
  logic                        match_valid;
  logic                        match_ready = 1'b0;
  logic [MATCH_START_BITS-1:0] match_start;

  match_scoreboard sb = new();
  int cycle_count = 0;
  int send_burst = 0;
  int ready_stretch = 0;
  int ready_stall = 0;

  rolling_hash_substring_matcher #(
    .MAX_PATTERN  (MAX_PATTERN),
    .POSITION_BITS(POSITION_BITS)
  ) uut (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .action     (action),
    .char_code  (char_code),
    .match_valid(match_valid),
    .match_ready(match_ready),
    .match_start(match_start)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles", cycle_count);
      $display("Test completed with failures");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && match_valid && match_ready) sb.check_match(match_start);
  end

  always @(negedge clk) begin
    int r;
    if (ready_stretch > 0) begin
      ready_stretch--;
      match_ready <= 1'b1;
    end else if (ready_stall > 0) begin
      ready_stall--;
      match_ready <= 1'b0;
    end else begin
      r = $urandom_range(0, 99);
      if (r < 5) begin
        ready_stretch = $urandom_range(50, 200);
        match_ready <= 1'b1;
      end else if (r < 65) begin
        match_ready <= 1'b1;
      end else if (r < 95) begin
        ready_stall = $urandom_range(0, 2);
        match_ready <= 1'b0;
      end else begin
        ready_stall = $urandom_range(15, 50);
        match_ready <= 1'b0;
      end
    end
  end

  task automatic idle_gap();
    int gap, r;
    if (send_burst > 0) begin
      send_burst--;
      gap = 0;
    end else begin
      r = $urandom_range(0, 99);
      if (r < 3) send_burst = $urandom_range(30, 80);
      if (r < 55) gap = 0;
      else if (r < 85) gap = $urandom_range(1, 3);
      else if (r < 97) gap = $urandom_range(4, 10);
      else gap = $urandom_range(20, 60);
    end
    if (gap > 0) begin
      item_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  task automatic send_item(input logic [ACTION_BITS-1:0] act, input logic [BYTE_BITS-1:0] code);
    action     <= act;
    char_code  <= code;
    item_valid <= 1'b1;
    @(posedge clk);
    while (!item_ready) @(posedge clk);
    sb.note_item(act, code);
    @(negedge clk);
    idle_gap();
  endtask

  // hold off the sender until every expected match position has been checked
  task automatic drain_results();
    item_valid <= 1'b0;
    @(negedge clk);
    while (sb.pending() != 0) @(negedge clk);
  endtask

  task automatic random_line();
    logic [BYTE_BITS-1:0] pat[$];
    int plen, tlen, alph, base, r, k;
    r = $urandom_range(0, 99);
    if (r < 6) plen = 0;
    else if (r < 14) plen = $urandom_range(60, 70);
    else plen = $urandom_range(1, 6);
    r = $urandom_range(0, 99);
    alph = (r < 45) ? 2 : (r < 80) ? 4 : 256;
    base = (alph == 256) ? 0 : $urandom_range(0, 256 - alph);
    if (plen > 10 || $urandom_range(0, 9) == 0) tlen = $urandom_range(130, 200);
    else tlen = $urandom_range(4, 30);
    if ($urandom_range(0, 7) == 0) drain_results();
    if ($urandom_range(0, 11) == 0) begin
      repeat ($urandom_range(10, 20))
        send_item(ACTION_BITS'($urandom_range(0, 3)), BYTE_BITS'($urandom));
    end else begin
      send_item(ACT_NEW_LINE, BYTE_BITS'($urandom));
      for (k = 0; k < plen; k++) begin
        pat.push_back(BYTE_BITS'(base + $urandom_range(0, alph - 1)));
        send_item(ACT_PATTERN, pat[k]);
      end
      k = 0;
      while (k < tlen) begin
        r = $urandom_range(0, 99);
        if (r < 3) begin
          send_item(ACT_UNUSED, BYTE_BITS'($urandom));
        end else if (r < 6 && k > 0) begin
          send_item(ACT_PATTERN, BYTE_BITS'($urandom));
        end else if (r < 26 && plen > 0 && plen <= tlen - k) begin
          foreach (pat[j]) send_item(ACT_TEXT, pat[j]);
          k += plen;
        end else begin
          send_item(ACT_TEXT, BYTE_BITS'(base + $urandom_range(0, alph - 1)));
          k++;
        end
      end
    end
  endtask

  initial begin
    int waited;
    repeat (5) @(negedge clk);
    rst <= 1'b0;

    send_item(ACT_NEW_LINE, 8'h00);
    send_item(ACT_TEXT, 8'h00);
    send_item(ACT_TEXT, 8'hFF);
    send_item(ACT_UNUSED, 8'hAA);
    send_item(ACT_NEW_LINE, 8'hFF);
    send_item(ACT_PATTERN, 8'hFF);
    send_item(ACT_PATTERN, 8'h00);
    send_item(ACT_UNUSED, 8'h55);
    send_item(ACT_TEXT, 8'hFF);
    send_item(ACT_TEXT, 8'h00);
    send_item(ACT_TEXT, 8'hFF);
    send_item(ACT_TEXT, 8'h00);
    send_item(ACT_PATTERN, 8'h07);
    send_item(ACT_TEXT, 8'hFF);
    send_item(ACT_TEXT, 8'h00);
    send_item(ACT_TEXT, 8'h01);
    send_item(ACT_UNUSED, 8'h00);
    send_item(ACT_TEXT, 8'h00);
    drain_results();

    while (sb.effective() < ITEM_TARGET) random_line();

    item_valid <= 1'b0;
    @(negedge clk);
    waited = 0;
    while (sb.pending() != 0 && waited < DRAIN_LIMIT) begin
      @(negedge clk);
      waited++;
    end
    repeat (TAIL_CYCLES) @(negedge clk);
    sb.report_leftovers();

    $display("Stimulus: %0d clears, %0d pattern bytes, %0d text bytes, %0d ignored items",
             sb.clears, sb.pattern_bytes, sb.text_bytes, sb.ignored);
    $display("Match positions checked: %0d, failures: %0d in %0d cycles",
             sb.matches_checked, sb.failures, cycle_count);
    if (sb.failures == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
